// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define PPF_ASSERT(lbl, c, r, p) \
    lbl: assert property (@(posedge c) disable iff (!r) (p)) \
        else $error("assertion failed");

// Implication built on the clocked assertion.
`define PPF_ASSERT_IMPL(lbl, c, r, a, b) \
    `PPF_ASSERT(lbl, c, r, (a) |-> (b))

// Next-cycle implication built on the clocked assertion.
`define PPF_ASSERT_NEXT(lbl, c, r, a, b) \
    `PPF_ASSERT(lbl, c, r, (a) |=> (b))

`endif

// File: rtl/ppf_pkg.sv
// Shared types and constants of the piecewise pair force block.
package ppf_pkg;

    localparam int DIST_W     = 16;
    localparam int COEF_W     = 32;
    localparam int BOUNDS_W   = 48;
    localparam int SQ_W       = 32;
    localparam int DVD_W      = 48;
    localparam int DIV_STAGES = DVD_W;
    localparam int IDX_W      = 4;

    localparam logic [IDX_W-1:0] REG_BOUNDS     = 4'd0;
    localparam logic [IDX_W-1:0] REG_NEAR_NUM   = 4'd1;
    localparam logic [IDX_W-1:0] REG_MID_SLOPE  = 4'd2;
    localparam logic [IDX_W-1:0] REG_MID_ICPT   = 4'd3;
    localparam logic [IDX_W-1:0] REG_OUTER_SLOPE = 4'd4;
    localparam logic [IDX_W-1:0] REG_OUTER_ICPT = 4'd5;
    localparam logic [IDX_W-1:0] REG_FAR_SHIFT  = 4'd6;
    localparam logic [IDX_W-1:0] REG_FAR_NUM    = 4'd7;

    localparam logic [COEF_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic              quot;
        logic              num_neg;
        logic              num_zero;
        logic              div_zero;
        logic [COEF_W-1:0] lin_res;
        logic              lin_sat;
    } meta_t;

endpackage

// File: rtl/ppf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module ppf_div
    import ppf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             src_valid,
    input  logic [DVD_W-1:0] dividend,
    input  logic [SQ_W-1:0]  divisor,
    input  meta_t            src_meta,
    output logic             res_valid,
    output logic [DVD_W-1:0] quotient,
    output meta_t            res_meta
);

    logic [DIV_STAGES-1:0] v_reg;
    logic [SQ_W-1:0]       rem_reg  [DIV_STAGES];
    logic [SQ_W-1:0]       dsr_reg  [DIV_STAGES];
    logic [DVD_W-1:0]      dvd_reg  [DIV_STAGES];
    logic [DVD_W-1:0]      q_reg    [DIV_STAGES];
    meta_t                 meta_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic             v_p;
            logic [SQ_W-1:0]  rem_p;
            logic [SQ_W-1:0]  dsr_p;
            logic [DVD_W-1:0] dvd_p;
            logic [DVD_W-1:0] q_p;
            meta_t            meta_p;
            logic [SQ_W:0]    trial;
            logic [SQ_W:0]    diff;
            logic             ge;
            logic [SQ_W-1:0]  rem_next;

            if (k == 0)
            begin : g_first
                assign v_p    = src_valid;
                assign rem_p  = '0;
                assign dsr_p  = divisor;
                assign dvd_p  = dividend;
                assign q_p    = '0;
                assign meta_p = src_meta;
            end
            else
            begin : g_rest
                assign v_p    = v_reg[k-1];
                assign rem_p  = rem_reg[k-1];
                assign dsr_p  = dsr_reg[k-1];
                assign dvd_p  = dvd_reg[k-1];
                assign q_p    = q_reg[k-1];
                assign meta_p = meta_reg[k-1];
            end

            assign trial    = {rem_p, dvd_p[DVD_W-1]};
            assign diff     = trial - {1'b0, dsr_p};
            assign ge       = (trial >= {1'b0, dsr_p});
            assign rem_next = ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_p;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    dsr_reg[k]  <= dsr_p;
                    dvd_reg[k]  <= {dvd_p[DVD_W-2:0], 1'b0};
                    q_reg[k]    <= {q_p[DVD_W-2:0], ge};
                    meta_reg[k] <= meta_p;
                end
            end
        end
    endgenerate

    assign res_valid = v_reg[DIV_STAGES-1];
    assign quotient  = q_reg[DIV_STAGES-1];
    assign res_meta  = meta_reg[DIV_STAGES-1];

endmodule

// File: rtl/piecewise_pair_force.sv
// Top level of the four-piece pair force evaluator.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------
//  in       | in_valid / in_stall    | distance
//  out      | out_valid / out_stall  | force_res, saturated
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat is taken per cycle while the input is not stalled.
// A result passes the input register, the select register, 48 divider stages and the output.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on the output stalls the input in the same cycle.
// Reset clears all valid bits and loads the coefficient registers.
// Configuration writes are always ready.
module piecewise_pair_force
    import ppf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [DIST_W-1:0]        distance,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [COEF_W-1:0] force_res,
    output logic                     saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [BOUNDS_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {PIECE_NEAR, PIECE_MID, PIECE_OUTER, PIECE_FAR} piece_t;

    logic [BOUNDS_W-1:0] bounds_reg;
    logic [COEF_W-1:0]   near_num_reg;
    logic [COEF_W-1:0]   mid_slope_reg;
    logic [COEF_W-1:0]   mid_icpt_reg;
    logic [COEF_W-1:0]   outer_slope_reg;
    logic [COEF_W-1:0]   outer_icpt_reg;
    logic [DIST_W-1:0]   far_shift_reg;
    logic [COEF_W-1:0]   far_num_reg;

    logic adv;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg      <= 48'd65971536535040;
            near_num_reg    <= 32'd141557760;
            mid_slope_reg   <= 32'd15729;
            mid_icpt_reg    <= 32'hFFF6_6666;
            outer_slope_reg <= 32'hFFFF_A3D7;
            outer_icpt_reg  <= 32'd1336934;
            far_shift_reg   <= 16'd14080;
            far_num_reg     <= 32'd1966080;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BOUNDS:      bounds_reg      <= cfg_data;
                REG_NEAR_NUM:    near_num_reg    <= cfg_data[COEF_W-1:0];
                REG_MID_SLOPE:   mid_slope_reg   <= cfg_data[COEF_W-1:0];
                REG_MID_ICPT:    mid_icpt_reg    <= cfg_data[COEF_W-1:0];
                REG_OUTER_SLOPE: outer_slope_reg <= cfg_data[COEF_W-1:0];
                REG_OUTER_ICPT:  outer_icpt_reg  <= cfg_data[COEF_W-1:0];
                REG_FAR_SHIFT:   far_shift_reg   <= cfg_data[DIST_W-1:0];
                REG_FAR_NUM:     far_num_reg     <= cfg_data[COEF_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stage A: input capture.
    logic              a_v_reg;
    logic [DIST_W-1:0] a_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_d_reg <= distance;
        end
    end

    // Stage B: piece select, square and linear product.
    piece_t                   piece_next;
    logic [DIST_W-1:0]        sq_op;
    logic signed [DIST_W:0]   far_diff;
    logic [COEF_W-1:0]        slope_sel;
    logic [COEF_W-1:0]        icpt_sel;
    logic [COEF_W-1:0]        num_sel;
    logic [SQ_W-1:0]          sq_next;
    logic signed [48:0]       prod_next;

    always_comb
    begin
        far_diff = $signed({1'b0, a_d_reg}) - $signed({1'b0, far_shift_reg});
        if (a_d_reg < bounds_reg[15:0])
        begin
            piece_next = PIECE_NEAR;
        end
        else if (a_d_reg < bounds_reg[31:16])
        begin
            piece_next = PIECE_MID;
        end
        else if (a_d_reg < bounds_reg[47:32])
        begin
            piece_next = PIECE_OUTER;
        end
        else
        begin
            piece_next = PIECE_FAR;
        end
        if (piece_next == PIECE_NEAR)
        begin
            sq_op   = a_d_reg;
            num_sel = near_num_reg;
        end
        else
        begin
            sq_op   = far_diff[DIST_W] ? DIST_W'(-far_diff) : far_diff[DIST_W-1:0];
            num_sel = far_num_reg;
        end
        if (piece_next == PIECE_MID)
        begin
            slope_sel = mid_slope_reg;
            icpt_sel  = mid_icpt_reg;
        end
        else
        begin
            slope_sel = outer_slope_reg;
            icpt_sel  = outer_icpt_reg;
        end
        sq_next   = SQ_W'(sq_op) * SQ_W'(sq_op);
        prod_next = 49'($signed(slope_sel)) * 49'($signed({1'b0, a_d_reg}));
    end

    logic               b_v_reg;
    logic               b_quot_reg;
    logic [SQ_W-1:0]    b_sq_reg;
    logic signed [48:0] b_prod_reg;
    logic [COEF_W-1:0]  b_icpt_reg;
    logic [COEF_W-1:0]  b_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_quot_reg <= (piece_next == PIECE_NEAR) || (piece_next == PIECE_FAR);
            b_sq_reg   <= sq_next;
            b_prod_reg <= prod_next;
            b_icpt_reg <= icpt_sel;
            b_num_reg  <= num_sel;
        end
    end

    // Linear piece finish and divider operand setup.
    logic signed [40:0] lin_shift;
    logic signed [41:0] lin_sum;
    meta_t              c_meta;
    logic [COEF_W-1:0]  num_mag;
    logic [DVD_W-1:0]   c_dividend;

    always_comb
    begin
        lin_shift = 41'(b_prod_reg >>> 8);
        lin_sum   = 42'(lin_shift) + 42'($signed(b_icpt_reg));
        num_mag   = b_num_reg[COEF_W-1] ? (~b_num_reg + 32'd1) : b_num_reg;
        c_dividend = {num_mag, 16'd0};
        c_meta.quot     = b_quot_reg;
        c_meta.num_neg  = b_num_reg[COEF_W-1];
        c_meta.num_zero = (b_num_reg == '0);
        c_meta.div_zero = (b_sq_reg == '0);
        if (lin_sum > 42'sd2147483647)
        begin
            c_meta.lin_res = S32_MAX;
            c_meta.lin_sat = 1'b1;
        end
        else if (lin_sum < -42'sd2147483648)
        begin
            c_meta.lin_res = S32_MIN;
            c_meta.lin_sat = 1'b1;
        end
        else
        begin
            c_meta.lin_res = lin_sum[COEF_W-1:0];
            c_meta.lin_sat = 1'b0;
        end
    end

    logic             d_v;
    logic [DVD_W-1:0] d_q;
    meta_t            d_meta;

    ppf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .src_valid (b_v_reg),
        .dividend  (c_dividend),
        .divisor   (b_sq_reg),
        .src_meta  (c_meta),
        .res_valid (d_v),
        .quotient  (d_q),
        .res_meta  (d_meta)
    );

    // Output stage: quotient sign, saturation and piece merge.
    logic [COEF_W-1:0] res_next;
    logic              sat_next;
    logic [DVD_W-1:0]  q_neg;

    always_comb
    begin
        q_neg = ~d_q + 48'd1;
        if (!d_meta.quot)
        begin
            res_next = d_meta.lin_res;
            sat_next = d_meta.lin_sat;
        end
        else if (d_meta.div_zero)
        begin
            sat_next = 1'b1;
            if (d_meta.num_zero)
            begin
                res_next = '0;
            end
            else if (d_meta.num_neg)
            begin
                res_next = S32_MAX;
            end
            else
            begin
                res_next = S32_MIN;
            end
        end
        else if (d_meta.num_neg)
        begin
            sat_next = (d_q > 48'h0000_7FFF_FFFF);
            res_next = sat_next ? S32_MAX : d_q[COEF_W-1:0];
        end
        else
        begin
            sat_next = (d_q > 48'h0000_8000_0000);
            res_next = sat_next ? S32_MIN : q_neg[COEF_W-1:0];
        end
    end

    logic              out_valid_reg;
    logic [COEF_W-1:0] force_reg;
    logic              sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            force_reg <= res_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_res = $signed(force_reg);
    assign saturated = sat_reg;

endmodule

// File: rtl/ppf_checker.sv
// Port-level checker of the pair force block and its bind.
`include "assert_macros.svh"

module ppf_checker
    import ppf_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [COEF_W-1:0] force_res,
    input logic                     saturated
);

    // The input stalls exactly when a result waits and is not taken.
    `PPF_ASSERT(a_stall_link, clk, rst_n, in_stall == (out_valid && out_stall))

    // A stalled result beat holds its value.
    `PPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(force_res))

    // A saturated result is one of the clipped values or the zero-numerator case.
    `PPF_ASSERT_IMPL(a_sat_value, clk, rst_n, out_valid && saturated, (force_res == 32'sh7FFF_FFFF) || (force_res == 32'sh8000_0000) || (force_res == 32'sd0))

endmodule

bind piecewise_pair_force ppf_checker u_ppf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .force_res (force_res),
    .saturated (saturated)
);
